@@ sv/pep_pkg.sv @@
`default_nettype none
package pep_pkg;

  // Sizes
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int MAX_ROW_WIDTH   = 512;
  localparam int ROW_AW          = $clog2(MAX_ROW_WIDTH);
  localparam int ROW_CW          = $clog2(MAX_ROW_WIDTH + 1);
  localparam int MAX_SCALE       = 15;
  localparam int Q_DEPTH         = 4;
  localparam int Q_AW            = $clog2(Q_DEPTH);
  localparam int Q_CW            = $clog2(Q_DEPTH + 1);

  // Item function codes
  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_PIXEL  = 2'd1;
  localparam logic [1:0] FUNC_REPLAY = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_PAL_DIRECT     = 3'd0;
  localparam logic [2:0] REG_R_BITS         = 3'd1;
  localparam logic [2:0] REG_G_BITS         = 3'd2;
  localparam logic [2:0] REG_B_BITS         = 3'd3;
  localparam logic [2:0] REG_CHANNEL_SHIFTS = 3'd4;
  localparam logic [2:0] REG_TRANSP_WORD    = 3'd5;
  localparam logic [2:0] REG_COLOR_COUNT    = 3'd6;
  localparam logic [2:0] REG_SCALE_FACTORS  = 3'd7;

  typedef struct packed {
    logic        pal_direct;
    logic [31:0] r_bits;
    logic [31:0] g_bits;
    logic [31:0] b_bits;
    logic [14:0] channel_shifts;
    logic [31:0] transp_word;
    logic [8:0]  color_count;
    logic [7:0]  scale_factors;
  } cfg_t;

  // One queued pixel run
  typedef struct packed {
    logic [31:0] word;
    logic        transp;
    logic        sep;
  } q_item_t;

  // Copy a byte into all four byte lanes
  function automatic logic [31:0] spread_byte(input logic [7:0] b);
    spread_byte = {b, b, b, b};
  endfunction

endpackage
`default_nettype wire

@@ sv/pep_ram.sv @@
`default_nettype none
module pep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Registered read returns old data on a same-edge write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

@@ sv/pep_front.sv @@
`default_nettype none
module pep_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_func,
  input  wire logic [7:0]             in_index,
  input  wire logic [7:0]             in_red,
  input  wire logic [7:0]             in_green,
  input  wire logic [7:0]             in_blue,
  input  wire logic [7:0]             in_hw_index,
  input  wire logic                   in_last_in_row,
  input  wire pep_pkg::cfg_t          cfg,
  input  wire logic [pep_pkg::Q_CW-1:0] q_count,
  output logic                        push,
  output pep_pkg::q_item_t            push_item
);
  import pep_pkg::*;

  logic              accept;
  logic              is_load;
  logic              is_pix;
  logic              is_rep;
  logic              row_ok;
  logic [Q_CW:0]     in_flight;
  logic [31:0]       conv_word;
  logic              row_wr_en;
  logic [ROW_CW-1:0] rp;
  logic [ROW_CW-1:0] rp_inc;
  logic [7:0]        row_rd_data;
  logic [PAL_AW-1:0] pal_rd_addr;
  logic [31:0]       pal_rd_data;
  logic              use_alpha;
  logic              transp;

  logic [ROW_CW-1:0] wp_r, wp_nxt;
  logic [ROW_CW-1:0] row_len_r, row_len_nxt;
  logic [ROW_CW-1:0] rep_pos_r, rep_pos_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_replay_r;
  logic [7:0]        s1_index_r;
  logic              s2_valid_r;
  logic [7:0]        s2_index_r;

  // Credit check: every run in flight has a queue slot waiting
  assign in_flight = {1'b0, q_count} + (Q_CW+1)'(s1_valid_r) + (Q_CW+1)'(s2_valid_r);
  assign in_ready  = in_flight < (Q_CW+1)'(Q_DEPTH);
  assign accept    = in_valid && in_ready;

  // Classify the item
  assign is_load = accept && (in_func == FUNC_LOAD);
  assign is_pix  = accept && (in_func == FUNC_PIXEL);
  assign is_rep  = accept && (in_func == FUNC_REPLAY);
  assign row_ok  = row_len_r != '0;

  // Palette entry conversion at load time
  always_comb begin
    if (cfg.pal_direct) begin
      conv_word = {24'd0, in_hw_index};
    end else begin
      conv_word = (cfg.r_bits & (spread_byte(in_red)   >> cfg.channel_shifts[4:0]))
                | (cfg.g_bits & (spread_byte(in_green) >> cfg.channel_shifts[9:5]))
                | (cfg.b_bits & (spread_byte(in_blue)  >> cfg.channel_shifts[14:10]));
    end
  end

  // Row buffer bookkeeping
  assign row_wr_en = is_pix && (wp_r < ROW_CW'(MAX_ROW_WIDTH));
  assign rp        = (rep_pos_r >= row_len_r) ? '0 : rep_pos_r;
  assign rp_inc    = rp + ROW_CW'(1);

  always_comb begin
    wp_nxt      = wp_r;
    row_len_nxt = row_len_r;
    rep_pos_nxt = rep_pos_r;
    if (is_pix) begin
      if (row_wr_en) begin
        wp_nxt = wp_r + ROW_CW'(1);
      end
      if (in_last_in_row) begin
        row_len_nxt = wp_nxt;
        wp_nxt      = '0;
        rep_pos_nxt = '0;
      end
    end else if (is_rep && row_ok) begin
      rep_pos_nxt = (rp_inc >= row_len_r) ? '0 : rp_inc;
    end
  end

  assign s1_valid_nxt = is_pix || (is_rep && row_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      row_len_r  <= '0;
      rep_pos_r  <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      wp_r       <= wp_nxt;
      row_len_r  <= row_len_nxt;
      rep_pos_r  <= rep_pos_nxt;
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s1_valid_r;
    end
  end

  // Payload of the two lookup stages
  always_ff @(posedge clk) begin
    s1_replay_r <= is_rep;
    s1_index_r  <= in_index;
    s2_index_r  <= pal_rd_addr;
  end

  pep_ram #(.WIDTH(8), .DEPTH(MAX_ROW_WIDTH)) u_row_ram (
    .clk     (clk),
    .wr_en   (row_wr_en),
    .wr_addr (wp_r[ROW_AW-1:0]),
    .wr_data (in_index),
    .rd_addr (rp[ROW_AW-1:0]),
    .rd_data (row_rd_data)
  );

  // Palette read in the cycle after accept, so replays and pixels share the port
  assign pal_rd_addr = s1_replay_r ? row_rd_data : s1_index_r;

  pep_ram #(.WIDTH(32), .DEPTH(PALETTE_ENTRIES)) u_pal_ram (
    .clk     (clk),
    .wr_en   (is_load),
    .wr_addr (in_index),
    .wr_data (conv_word),
    .rd_addr (pal_rd_addr),
    .rd_data (pal_rd_data)
  );

  // Transparency and queue entry
  assign use_alpha = !cfg.color_count[8];
  assign transp    = use_alpha && (s2_index_r == 8'hff);

  assign push             = s2_valid_r;
  assign push_item.word   = transp ? cfg.transp_word : pal_rd_data;
  assign push_item.transp = transp;
  assign push_item.sep    = use_alpha && (cfg.transp_word == 32'd0);

endmodule
`default_nettype wire

@@ sv/pep_queue.sv @@
`default_nettype none
module pep_queue (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     push,
  input  wire pep_pkg::q_item_t         push_item,
  input  wire logic                     pop,
  output logic [pep_pkg::Q_CW-1:0]      count,
  output pep_pkg::q_item_t              head
);
  import pep_pkg::*;

  q_item_t         slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] count_r, count_nxt;

  // Occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + Q_CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign count = count_r;
  assign head  = slot_r[rd_ptr_r];

endmodule
`default_nettype wire

@@ sv/pep_back.sv @@
`default_nettype none
module pep_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [7:0]       scale_factors,
  input  wire logic             q_valid,
  input  wire pep_pkg::q_item_t q_head,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           out_color_word,
  output logic [7:0]            out_alpha_byte,
  output logic                  out_alpha_valid,
  output logic                  out_last
);
  import pep_pkg::*;

  logic [3:0]  hfac;
  logic        take;
  logic        need;
  logic        valid_r, valid_nxt;
  logic [3:0]  k_r, k_nxt;
  logic        last_r, last_nxt;
  logic [31:0] word_r;
  logic        transp_r;
  logic        sep_r;

  // Horizontal factor, zero taken as one
  always_comb begin
    hfac = scale_factors[3:0];
    if (hfac == 4'd0) begin
      hfac = 4'd1;
    end else if (hfac > 4'(MAX_SCALE)) begin
      hfac = 4'(MAX_SCALE);
    end
  end

  // Advance one copy per taken item, fetch next run after the last copy
  assign take  = valid_r && out_ready;
  assign need  = !valid_r || (take && last_r);
  assign q_pop = need && q_valid;

  always_comb begin
    valid_nxt = valid_r;
    k_nxt     = k_r;
    last_nxt  = last_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
      k_nxt     = 4'd1;
      last_nxt  = hfac == 4'd1;
    end else if (take) begin
      if (last_r) begin
        valid_nxt = 1'b0;
      end else begin
        k_nxt    = k_r + 4'd1;
        last_nxt = (k_r + 4'd1) == hfac;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    last_r <= last_nxt;
    if (q_pop) begin
      word_r   <= q_head.word;
      transp_r <= q_head.transp;
      sep_r    <= q_head.sep;
    end
  end

  assign out_valid       = valid_r;
  assign out_color_word  = word_r;
  assign out_alpha_byte  = (sep_r && transp_r) ? 8'hff : 8'h00;
  assign out_alpha_valid = sep_r;
  assign out_last        = last_r;

endmodule
`default_nettype wire

@@ sv/palette_expand_pixel_replicate.sv @@
// Indexed-pixel expander: load items (tuser 0) convert an RGB palette entry into a packed
// 32-bit word (or store the global index in palette mode); pixel items (tuser 1) look the
// entry up and emit it horizontal-factor times, recording the index in a row buffer; replay
// items (tuser 2) re-emit the next index of the last completed row. The output runs at one
// item per cycle unless out_tready stalls it, so a pixel or replay yields h copies (h = 1..15,
// the horizontal factor) and the input accepts one item per cycle while the run queue has
// room; loads and unused codes produce no output. After the edge that accepts an item (the
// row-buffer read happens at that edge), its result passes the palette read, a run queue
// slot, then the output register before it is first offered.
// Palette and row storage need no initialization pass after reset.
`default_nettype none
module palette_expand_pixel_replicate (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // index, red, green, blue, hw_index
  input  wire logic [1:0]  in_tuser,   // func
  input  wire logic        in_tlast,   // last_in_row
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // color_word, alpha_byte
  output logic [0:0]       out_tuser,  // alpha_valid
  output logic             out_tlast,  // last copy of the run
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import pep_pkg::*;

  cfg_t            cfg_r;
  logic [Q_CW-1:0] q_count;
  logic            push;
  q_item_t         push_item;
  logic            q_pop;
  q_item_t         q_head;
  logic [31:0]     color_word;
  logic [7:0]      alpha_byte;
  logic            alpha_valid;

  // Register file, written any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pal_direct     <= 1'b0;
      cfg_r.r_bits         <= 32'h00ff_0000;
      cfg_r.g_bits         <= 32'h0000_ff00;
      cfg_r.b_bits         <= 32'h0000_00ff;
      cfg_r.channel_shifts <= 15'd6152;
      cfg_r.transp_word    <= 32'd0;
      cfg_r.color_count    <= 9'd256;
      cfg_r.scale_factors  <= 8'd17;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAL_DIRECT:     cfg_r.pal_direct     <= cfg_data[0];
        REG_R_BITS:         cfg_r.r_bits         <= cfg_data;
        REG_G_BITS:         cfg_r.g_bits         <= cfg_data;
        REG_B_BITS:         cfg_r.b_bits         <= cfg_data;
        REG_CHANNEL_SHIFTS: cfg_r.channel_shifts <= cfg_data[14:0];
        REG_TRANSP_WORD:    cfg_r.transp_word    <= cfg_data;
        REG_COLOR_COUNT:    cfg_r.color_count    <= cfg_data[8:0];
        REG_SCALE_FACTORS:  cfg_r.scale_factors  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  pep_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_func         (in_tuser),
    .in_index        (in_tdata[7:0]),
    .in_red          (in_tdata[15:8]),
    .in_green        (in_tdata[23:16]),
    .in_blue         (in_tdata[31:24]),
    .in_hw_index     (in_tdata[39:32]),
    .in_last_in_row  (in_tlast),
    .cfg             (cfg_r),
    .q_count         (q_count),
    .push            (push),
    .push_item       (push_item)
  );

  pep_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .count     (q_count),
    .head      (q_head)
  );

  pep_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .scale_factors   (cfg_r.scale_factors),
    .q_valid         (q_count != '0),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_color_word  (color_word),
    .out_alpha_byte  (alpha_byte),
    .out_alpha_valid (alpha_valid),
    .out_last        (out_tlast)
  );

  assign out_tdata = {alpha_byte, color_word};
  assign out_tuser = alpha_valid;

endmodule
`default_nettype wire

@@ sv/pep_checker.sv @@
`default_nettype none
module pep_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [39:0] in_tdata,
  input wire logic [1:0]  in_tuser,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [0:0]  out_tuser,
  input wire logic        out_tlast,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [2:0]  cfg_index,
  input wire logic [31:0] cfg_data
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Copies of one run follow without a gap and carry the same word
  a_run_copies: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && $stable(out_tdata))
    else $error("horizontal run broken");

  // A set alpha byte only appears with the separate alpha flag, and is full
  a_alpha_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[39:32] != 8'h00) |-> out_tuser[0] && (out_tdata[39:32] == 8'hff))
    else $error("alpha byte without alpha flag");

  // A transparent pixel in separate-alpha mode carries a zero word
  a_alpha_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[39:32] == 8'hff) |-> out_tdata[31:0] == 32'd0)
    else $error("transparent pixel with nonzero word");

endmodule

bind palette_expand_pixel_replicate pep_checker u_pep_checker (.*);
`default_nettype wire
